// ===== rtl/bis_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and codes of the binary interpolation search block
package bis_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam int IN_KEY_W    = 32;
  localparam int ENTRY_IDX_W = 10;
  localparam int POS_W       = 10;
  localparam int ENTRIES_W   = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1024;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd1;

  typedef enum logic [2:0] {ADR_LO, ADR_HI, ADR_NX, ADR_J, ADR_K} adr_sel_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_LO, CAP_HI, CAP_NX, CAP_J, CAP_K} cap_sel_t;
  typedef enum logic [1:0] {RES_MISS, RES_AT_NX, RES_AT_K} res_sel_t;

  typedef struct packed {
    logic     load;
    logic     start;
    logic     rd_en;
    adr_sel_t rd_sel;
    cap_sel_t cap;
    logic     prb_init;
    logic     prb_eq;
    logic     mul_step;
    logic     div_init;
    logic     div_step;
    logic     prb_fin;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     jmp_mul;
    logic     jmp_idx;
    logic     jmp_grow;
    logic     jmp_fin;
    logic     scan_init;
    logic     scan_next;
    logic     res_set;
    res_sel_t res;
    logic     out_load;
  } bis_cmd_t;

  typedef struct packed {
    logic first;
    logic out_of_range;
    logic d_zero;
    logic cnt_zero;
    logic hit_nx;
    logic small_win;
    logic j_edge;
    logic j_stop;
    logic k_hit;
    logic k_last;
  } bis_sts_t;

endpackage

// ===== rtl/bis_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests, results and configuration writes
interface bis_req_if;
  import bis_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ENTRY_IDX_W-1:0]     entry_index;
  logic signed [IN_KEY_W-1:0] key_value;
  modport source(output valid, func, entry_index, key_value, input ready);
  modport sink(input valid, func, entry_index, key_value, output ready);
endinterface

interface bis_rsp_if;
  import bis_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  modport source(output valid, found, position, input ready);
  modport sink(input valid, found, position, output ready);
endinterface

interface bis_cfg_if;
  import bis_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/bis_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bis_ctrl.sv =====
`timescale 1ns / 1ps
// search sequencer: steps the datapath through probe, jump and scan phases
module bis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  bis_pkg::bis_sts_t sts,
  output bis_pkg::bis_cmd_t cmd
);
  import bis_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LO_RD, S_LO_CAP, S_HI_CAP, S_CHK, S_MUL, S_DIV,
    S_NX_RD, S_NX_CAP, S_NX_CHK, S_SQRT, S_JIDX, S_JCHK, S_JCAP, S_JTST, S_JMUL,
    S_SC_RD, S_SC_CAP, S_SC_CHK, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_func == FUNC_SEARCH) begin
          cmd.start  = 1'b1;
          state_next = S_LO_RD;
        end else if (in_valid) begin
          cmd.load = 1'b1;
        end
      end
      S_LO_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADR_LO;
        state_next = S_LO_CAP;
      end
      S_LO_CAP: begin
        cmd.cap    = CAP_LO;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADR_HI;
        state_next = S_HI_CAP;
      end
      S_HI_CAP: begin
        cmd.cap    = CAP_HI;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.first && sts.out_of_range) begin
          cmd.res_set = 1'b1;
          cmd.res     = RES_MISS;
          state_next  = S_DONE;
        end else if (sts.d_zero) begin
          cmd.prb_eq = 1'b1;
          state_next = S_NX_RD;
        end else begin
          cmd.prb_init = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.cnt_zero) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.cnt_zero) begin
          cmd.prb_fin = 1'b1;
          state_next  = S_NX_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_NX_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADR_NX;
        state_next = S_NX_CAP;
      end
      S_NX_CAP: begin
        cmd.cap    = CAP_NX;
        state_next = S_NX_CHK;
      end
      S_NX_CHK: begin
        if (sts.hit_nx) begin
          cmd.res_set = 1'b1;
          cmd.res     = RES_AT_NX;
          state_next  = S_DONE;
        end else if (sts.small_win) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SC_RD;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.cnt_zero) begin
          cmd.jmp_mul = 1'b1;
          state_next  = S_JIDX;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_JIDX: begin
        cmd.jmp_idx = 1'b1;
        state_next  = S_JCHK;
      end
      S_JCHK: begin
        if (sts.j_edge) begin
          cmd.jmp_fin = 1'b1;
          state_next  = S_LO_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADR_J;
          state_next = S_JCAP;
        end
      end
      S_JCAP: begin
        cmd.cap    = CAP_J;
        state_next = S_JTST;
      end
      S_JTST: begin
        if (sts.j_stop) begin
          cmd.jmp_fin = 1'b1;
          state_next  = S_LO_RD;
        end else begin
          cmd.jmp_grow = 1'b1;
          state_next   = S_JMUL;
        end
      end
      S_JMUL: begin
        cmd.jmp_mul = 1'b1;
        state_next  = S_JIDX;
      end
      S_SC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADR_K;
        state_next = S_SC_CAP;
      end
      S_SC_CAP: begin
        cmd.cap    = CAP_K;
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (sts.k_hit) begin
          cmd.res_set = 1'b1;
          cmd.res     = RES_AT_K;
          state_next  = S_DONE;
        end else if (sts.k_last) begin
          cmd.res_set = 1'b1;
          cmd.res     = RES_MISS;
          state_next  = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SC_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_func == FUNC_SEARCH) |=> (state == S_LO_RD))
    else $error("search item did not start a search");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE && out_valid))
    else $error("pending result overwritten");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_step, cmd.div_step, cmd.sqrt_step, cmd.jmp_grow}))
    else $error("more than one iterative unit stepped");
`endif

endmodule

// ===== rtl/bis_dp.sv =====
`timescale 1ns / 1ps
// search datapath: window registers, serial multiply/divide, serial sqrt, jump logic
module bis_dp #(
  parameter int TABLE_DEPTH = bis_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = bis_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bis_pkg::bis_cmd_t                   cmd,
  output bis_pkg::bis_sts_t                   sts,
  input  logic [bis_pkg::ENTRY_IDX_W-1:0]     entry_index,
  input  logic signed [bis_pkg::IN_KEY_W-1:0] key_value,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr,
  output logic [KEY_WIDTH-1:0]                ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr,
  input  logic [KEY_WIDTH-1:0]                ram_rdata,
  output logic                                found,
  output logic [bis_pkg::POS_W-1:0]           position
);
  import bis_pkg::*;

  localparam int KW  = KEY_WIDTH;
  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int SW  = IW + 1;
  localparam int SQW = (SW + 1) / 2;
  localparam int PW  = KW + 1 + SW;
  localparam int CW  = $clog2(PW + 1);
  localparam int JW  = SW + 2;
  localparam int PRW = JW + SQW;
  localparam int QW  = PW + 3;
  localparam int MW  = ((PRW + 2) > QW ? (PRW + 2) : QW) + 1;
  localparam int EW  = (SW > ENTRIES_W) ? SW : ENTRIES_W;
  localparam logic signed [MW-1:0] ONE_S = MW'(1);

  // configuration
  logic                 growth_mode;
  logic [ENTRIES_W-1:0] entries_in_use;

  // search state
  logic signed [KW-1:0] x, klo, khi, knx, kj, kk;
  logic [IW-1:0]        lo, hi, nx, j, k;
  logic                 first;
  logic                 right;
  logic [PW-1:0]        acc, mcand, num;
  logic [SW-1:0]        mplier;
  logic [KW:0]          rem;
  logic [CW-1:0]        cnt;
  logic [SQW-1:0]       r;
  logic [JW-1:0]        i;
  logic [PRW-1:0]       prod;
  logic                 res_found;
  logic [IW-1:0]        res_pos;

  logic signed [KW-1:0] xn;
  logic signed [KW:0]   diff, dd;
  logic [KW:0]          amag, dmag;
  logic                 dneg;
  logic [SW-1:0]        size;
  logic [EW-1:0]        e_ext;
  logic [IW-1:0]        hi_init;
  logic [KW+1:0]        rem_sh;
  logic                 qbit;
  logic [KW:0]          rem_new;
  logic signed [QW-1:0] qu, qs;
  logic signed [MW-1:0] lo_e, nx_e, prod_e, s_e, ptarget, jv;
  logic [SQW-1:0]       t;
  logic [2*SQW-1:0]     tt;
  logic [PRW-1:0]       prod_next;

  function automatic logic [IW-1:0] clampi(input logic signed [MW-1:0] v,
                                           input logic [IW-1:0] l,
                                           input logic [IW-1:0] h);
    logic signed [MW-1:0] le, he;
    le = MW'(l);
    he = MW'(h);
    if (v < le) return l;
    else if (v > he) return h;
    else return IW'(v);
  endfunction

  // narrow keys are cut, wide keys sign extended
  assign xn = KW'(key_value);

  assign ram_we    = cmd.load && (EW'(entry_index) < EW'(TABLE_DEPTH));
  assign ram_waddr = IW'(entry_index);
  assign ram_wdata = xn;
  assign ram_re    = cmd.rd_en;

  always_comb begin
    case (cmd.rd_sel)
      ADR_LO:  ram_raddr = lo;
      ADR_HI:  ram_raddr = hi;
      ADR_NX:  ram_raddr = nx;
      ADR_J:   ram_raddr = j;
      ADR_K:   ram_raddr = k;
      default: ram_raddr = lo;
    endcase
  end

  // entry count clamped into 1..depth
  assign e_ext = EW'(entries_in_use);
  always_comb begin
    if (e_ext == '0) hi_init = '0;
    else if (e_ext > EW'(TABLE_DEPTH)) hi_init = IW'(TABLE_DEPTH - 1);
    else hi_init = IW'(e_ext - EW'(1));
  end

  assign diff = $signed({x[KW-1], x}) - $signed({klo[KW-1], klo});
  assign dd   = $signed({khi[KW-1], khi}) - $signed({klo[KW-1], klo});
  assign amag = diff[KW] ? 1'(0) - diff : diff;
  assign dmag = dd[KW] ? 1'(0) - dd : dd;
  assign dneg = diff[KW] ^ dd[KW];
  assign size = SW'(hi) - SW'(lo) + SW'(1);

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem, num[PW-1]};
  assign qbit    = (rem_sh >= {1'b0, dmag});
  assign rem_new = qbit ? (KW+1)'(rem_sh - {1'b0, dmag}) : rem_sh[KW:0];

  // truncating signed quotient
  assign qu = $signed({3'b000, num});
  assign qs = dneg ? -qu : qu;

  assign lo_e    = MW'(lo);
  assign nx_e    = MW'(nx);
  assign prod_e  = MW'(prod);
  assign s_e     = MW'(r);
  assign ptarget = lo_e + MW'(qs) + (first ? ONE_S : -ONE_S);
  assign jv      = right ? (nx_e + prod_e - ONE_S) : (nx_e - prod_e + ONE_S);

  // square root, one result bit per cycle from the top
  assign t  = r | (SQW'(1) << (cnt - CW'(1)));
  assign tt = (2*SQW)'(t) * (2*SQW)'(t);

  assign prod_next = PRW'(i) * PRW'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_mode    <= 1'b0;
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GROWTH_MODE:    growth_mode <= cfg_data[0];
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x     <= xn;
      lo    <= '0;
      hi    <= hi_init;
      first <= 1'b1;
    end
    case (cmd.cap)
      CAP_LO:  klo <= ram_rdata;
      CAP_HI:  khi <= ram_rdata;
      CAP_NX:  knx <= ram_rdata;
      CAP_J:   kj  <= ram_rdata;
      CAP_K:   kk  <= ram_rdata;
      default: ;
    endcase
    if (cmd.prb_init) begin
      mcand  <= PW'(amag);
      mplier <= size;
      acc    <= '0;
      cnt    <= CW'(SW);
    end
    if (cmd.mul_step) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - CW'(1);
    end
    if (cmd.div_init) begin
      num <= acc;
      rem <= '0;
      cnt <= CW'(PW);
    end
    if (cmd.div_step) begin
      num <= {num[PW-2:0], qbit};
      rem <= rem_new;
      cnt <= cnt - CW'(1);
    end
    if (cmd.prb_fin) nx <= clampi(ptarget, lo, hi);
    if (cmd.prb_eq) nx <= lo;
    if (cmd.sqrt_init) begin
      r     <= '0;
      cnt   <= CW'(SQW);
      i     <= JW'(1);
      right <= (x > knx);
    end
    if (cmd.sqrt_step) begin
      if (tt <= (2*SQW)'(size)) r <= t;
      cnt <= cnt - CW'(1);
    end
    if (cmd.jmp_mul) prod <= prod_next;
    if (cmd.jmp_idx) j <= clampi(jv, lo, hi);
    if (cmd.jmp_grow) i <= growth_mode ? (i << 1) : (i + JW'(1));
    if (cmd.jmp_fin) begin
      first <= 1'b0;
      if (right) begin
        lo <= clampi(nx_e + prod_e - s_e, lo, hi);
        hi <= clampi(nx_e + prod_e, lo, hi);
      end else begin
        lo <= clampi(nx_e - prod_e, lo, hi);
        hi <= clampi(nx_e - prod_e + s_e, lo, hi);
      end
    end
    if (cmd.scan_init) k <= lo;
    if (cmd.scan_next) k <= k + IW'(1);
    if (cmd.res_set) begin
      case (cmd.res)
        RES_AT_NX: begin
          res_found <= 1'b1;
          res_pos   <= nx;
        end
        RES_AT_K: begin
          res_found <= 1'b1;
          res_pos   <= k;
        end
        default: begin
          res_found <= 1'b0;
          res_pos   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      found    <= res_found;
      position <= POS_W'(res_pos);
    end
  end

  assign sts.first        = first;
  assign sts.out_of_range = (x < klo) || (x > khi);
  assign sts.d_zero       = (khi == klo);
  assign sts.cnt_zero     = (cnt == '0);
  assign sts.hit_nx       = (knx == x);
  assign sts.small_win    = (size <= SW'(3));
  assign sts.j_edge       = right ? (j >= hi) : (j <= lo);
  assign sts.j_stop       = right ? (x <= kj) : (x >= kj);
  assign sts.k_hit        = (kk == x);
  assign sts.k_last       = (k == hi);

`ifndef SYNTHESIS
  a_window_ordered: assert property (@(posedge clk) disable iff (rst)
    cmd.jmp_fin |=> (lo <= hi))
    else $error("jump produced an empty window");
`endif

endmodule

// ===== rtl/binary_interpolation_search_top.sv =====
`timescale 1ns / 1ps
// top level of the binary interpolation search block
//
// Holds a table of TABLE_DEPTH signed keys (KEY_WIDTH bits) in a single ram and
// answers requests one item at a time. A load item (func 0) writes one entry and
// gives no result; an index at or beyond the depth is dropped. A search item
// (func 1) looks for key_value among the first entries_in_use entries, which
// must be sorted ascending and written beforehand, and returns one result item:
// found and the matching position, or found 0 and position 0. Each interpolation
// pass computes its probe with a bit-serial multiplier over SW = log2(depth)+1
// bits and a restoring divider over PW = KEY_WIDTH+SW+1 bits; each pass that
// misses adds a serial square root over SQW bits, SQW being half of SW rounded
// up, and jump steps, every table access going through the one registered ram
// read port. Windows of three or fewer entries are scanned entry by entry.
// Request ready is high only while no search is in flight; a finished result
// sits in an output register until taken. Configuration: register 0 is
// growth_mode (jump multiplier +1 or x2), register 1 is entries_in_use (0 acts
// as 1, above the depth acts as the depth). Write it only while the block is
// idle. There is no clearing pass after reset.
module binary_interpolation_search_top #(
  parameter int TABLE_DEPTH = bis_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = bis_pkg::DEF_KEY_WIDTH
) (
  input logic   clk,
  input logic   rst,
  bis_req_if.sink   req,
  bis_rsp_if.source rsp,
  bis_cfg_if.sink   cfg
);
  import bis_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  bis_cmd_t cmd;
  bis_sts_t sts;

  // ram ports
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (req.entry_index),
    .key_value   (req.key_value),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .found       (rsp.found),
    .position    (rsp.position)
  );

  // key table
  bis_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
